// ===== hw/rtl/dcnt_pkg.sv =====
// ----------------------------------------------------------------------------
// dcnt_pkg
// Shared constants, types and the state encoding of the divisor counter.
// ----------------------------------------------------------------------------
package dcnt_pkg;

  localparam int PrimeLimit = 1048576;
  localparam int NumberBits = 40;
  localparam int MapBits    = PrimeLimit / 2 + 1;
  localparam int MapAw      = $clog2(MapBits);
  localparam int CountBits  = 16;
  localparam int ExpBits    = 7;
  localparam int DivBits    = 22;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_SIEVE_RD, ST_SIEVE_CHK, ST_SIEVE_MARK,
    ST_IDLE, ST_TWO, ST_TRY, ST_LOOK, ST_DIV, ST_DIVWAIT, ST_EXP, ST_FINISH, ST_OUT
  } dcnt_state_t;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Saturating product of the count.
  function automatic logic [CountBits-1:0] mul_sat(input logic [CountBits-1:0] a,
                                                    input logic [ExpBits-1:0] b);
    logic [CountBits+ExpBits-1:0] p;
    p = a * b;
    if (p > {{ExpBits{1'b0}}, {CountBits{1'b1}}}) return {CountBits{1'b1}};
    return p[CountBits-1:0];
  endfunction

endpackage

// ===== hw/rtl/dcnt_ram.sv =====
// ----------------------------------------------------------------------------
// dcnt_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dcnt_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/dcnt_div.sv =====
// ----------------------------------------------------------------------------
// dcnt_div
// Restoring divider, one quotient bit a cycle: value / divisor and whether the remainder is zero.
// ----------------------------------------------------------------------------
module dcnt_div
  import dcnt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  div_ctl_t              ctl,
  input  logic [NumberBits-1:0] dividend,
  input  logic [DivBits-1:0]    divisor,
  output div_sts_t              sts,
  output logic [NumberBits-1:0] quotient,
  output logic                  rem_zero
);

  localparam int CntBits = $clog2(NumberBits + 1);

  logic [DivBits:0]        rem;
  logic [NumberBits-1:0]   quo;
  logic [CntBits-1:0]      cnt;
  logic                    busy;
  logic                    done;
  logic [DivBits:0]        shifted;
  logic [DivBits+1:0]      diff;

  assign shifted = {rem[DivBits-1:0], quo[NumberBits-1]};
  assign diff    = {1'b0, shifted} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CntBits'(NumberBits);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        // shift in one bit, subtract if it fits
        if (!diff[DivBits+1]) begin
          rem <= diff[DivBits:0];
          quo <= {quo[NumberBits-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[NumberBits-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quo;
  assign rem_zero = (rem == '0);

endmodule

// ===== hw/rtl/divisor_count_trial_division.sv =====
// ----------------------------------------------------------------------------
// divisor_count_trial_division
// Divisor count by trial division over odd primes from a sieve map in RAM.
// ----------------------------------------------------------------------------
// channel | dir | signals                 | payload
// s_axis  | in  | tvalid tready tdata[39:0]| number
// m_axis  | out | tvalid tready tdata[15:0]| divisor_count; tuser: zero_input
// After reset the map RAM is cleared and then sieved, with s_axis_tready
// low. Per request: factors of two are shifted out one at a time, each odd
// candidate is looked up in the map and skipped if composite, and each
// odd prime is tried in the divider, again while it divides. One request
// at a time; the result waits in the output register until taken.
// ----------------------------------------------------------------------------
module divisor_count_trial_division
  import dcnt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [39:0] number
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] divisor_count
  output logic        m_axis_tuser    // [0] zero_input
);

  dcnt_state_t state, state_next;

  logic [MapAw-1:0]       addr;
  logic                   we, wbit, rbit;
  logic [MapAw:0]         idx;      // clear index
  logic [DivBits-1:0]     si;       // sieve prime
  logic [DivBits:0]       sj;       // sieve multiple
  logic [NumberBits-1:0]  rv;
  logic [DivBits-1:0]     d;
  logic [CountBits-1:0]   prod;
  logic [ExpBits-1:0]     ex;
  logic                   zflag;
  div_ctl_t               dctl;
  div_sts_t               dsts;
  logic [NumberBits-1:0]  quo;
  logic                   rz;
  logic [2*DivBits-1:0]   dsq;
  logic [2*DivBits-1:0]   isq;

  dcnt_ram #(.Width(1), .Depth(MapBits)) u_map (
    .clk(clk), .we(we), .addr(addr), .wdata(wbit), .rdata(rbit)
  );

  dcnt_div u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(rv), .divisor(d),
    .sts(dsts), .quotient(quo), .rem_zero(rz)
  );

  assign dsq = d * d;
  assign isq = si * si;

  // next state and memory port
  always_comb begin
    state_next = state;
    we   = 1'b0;
    wbit = 1'b0;
    addr = '0;
    dctl.start = 1'b0;
    case (state)
      ST_CLEAR: begin
        we   = 1'b1;
        addr = idx[MapAw-1:0];
        if (idx == (MapAw+1)'(MapBits - 1)) state_next = ST_SIEVE_RD;
      end
      ST_SIEVE_RD: begin
        addr = MapAw'(si >> 1);
        if (isq > (2*DivBits)'(PrimeLimit)) state_next = ST_IDLE;
        else state_next = ST_SIEVE_CHK;
      end
      ST_SIEVE_CHK: begin
        addr = MapAw'(si >> 1);
        if (rbit) state_next = ST_SIEVE_RD;
        else state_next = ST_SIEVE_MARK;
      end
      ST_SIEVE_MARK: begin
        addr = MapAw'(sj >> 1);
        if (sj <= (DivBits+1)'(PrimeLimit)) begin
          we   = 1'b1;
          wbit = 1'b1;
        end else begin
          state_next = ST_SIEVE_RD;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = (s_axis_tdata == '0) ? ST_OUT : ST_TWO;
      end
      ST_TWO: begin
        if (rv[0]) state_next = ST_TRY;
      end
      ST_TRY: begin
        addr = MapAw'(d >> 1);
        if ({{(2*NumberBits-2*DivBits){1'b0}}, dsq} > {{NumberBits{1'b0}}, rv})
          state_next = ST_FINISH;
        else if (d <= DivBits'(PrimeLimit)) state_next = ST_LOOK;
        else state_next = ST_DIV;
      end
      ST_LOOK: begin
        state_next = rbit ? ST_TRY : ST_DIV;
      end
      ST_DIV: begin
        dctl.start = 1'b1;
        state_next = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (dsts.done) state_next = rz ? ST_DIV : ST_EXP;
      end
      ST_EXP:    state_next = ST_TRY;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: begin
        if (m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      si    <= DivBits'(3);
      sj    <= '0;
      rv    <= '0;
      prod  <= CountBits'(1);
      ex    <= ExpBits'(1);
      d     <= DivBits'(3);
      zflag <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: idx <= idx + 1'b1;
        ST_SIEVE_CHK: begin
          if (rbit) si <= si + DivBits'(2);
          else      sj <= (DivBits+1)'(isq);
        end
        ST_SIEVE_MARK: begin
          if (sj <= (DivBits+1)'(PrimeLimit)) sj <= sj + {si, 1'b0};
          else si <= si + DivBits'(2);
        end
        ST_IDLE: begin
          rv    <= s_axis_tdata;
          prod  <= CountBits'(1);
          ex    <= ExpBits'(1);
          d     <= DivBits'(3);
          zflag <= (s_axis_tdata == '0);
        end
        ST_TWO: begin
          if (!rv[0]) begin
            rv <= rv >> 1;
            ex <= ex + 1'b1;
          end else begin
            prod <= mul_sat(prod, ex);
            ex   <= ExpBits'(1);
          end
        end
        ST_LOOK: if (rbit) d <= d + DivBits'(2);
        ST_DIVWAIT: begin
          if (dsts.done) begin
            if (rz) begin
              rv <= quo;
              ex <= ex + 1'b1;
            end
          end
        end
        ST_EXP: begin
          prod <= mul_sat(prod, ex);
          ex   <= ExpBits'(1);
          d    <= d + DivBits'(2);
        end
        ST_FINISH: if (rv != NumberBits'(1)) prod <= mul_sat(prod, ExpBits'(2));
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = zflag ? '0 : prod;
  assign m_axis_tuser  = zflag;

endmodule

// ===== tb/divisor_count_checker.sv =====
// ----------------------------------------------------------------------------
// divisor_count_checker
// Watches both stream channels of the divisor counter. For each accepted
// request it computes the divisor count by trial division and queues it;
// each accepted result is compared with the oldest queued count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module divisor_count_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [39:0] number
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [15:0] divisor_count
  input  logic        m_axis_tuser,   // [0] zero_input
  output int          fail_count,
  output int          pending
);
  import dcnt_pkg::*;

  localparam int QDepth = 16;
  localparam int QAw    = $clog2(QDepth);

  typedef struct {
    logic [CountBits-1:0] divisor_count;
    logic                 zero_input;
  } count_t;

  count_t          count_fifo [QDepth];
  logic [QAw-1:0]  wr_ptr;
  logic [QAw-1:0]  rd_ptr;
  int              wr_cnt;
  int              rd_cnt;

  // Saturating multiply of the running divisor count.
  function automatic logic [CountBits-1:0] sat_mul(logic [CountBits-1:0] a, longint unsigned f);
    longint unsigned p;
    p = longint'(a) * f;
    return (p > 65535) ? 16'hFFFF : p[CountBits-1:0];
  endfunction

  // Composite odd divisors never divide once their prime factors are gone,
  // so trying every odd divisor gives the same count as a prime-only search.
  function automatic count_t count_divisors(logic [NumberBits-1:0] number);
    count_t          res;
    longint unsigned rem;
    longint unsigned d;
    longint unsigned e;
    rem = number;
    res.zero_input = (rem == 0);
    res.divisor_count = CountBits'(1);
    if (rem == 0) begin
      res.divisor_count = '0;
      return res;
    end
    e = 1;
    while (rem[0] == 1'b0) begin
      e++;
      rem = rem >> 1;
    end
    res.divisor_count = sat_mul(res.divisor_count, e);
    for (d = 3; d * d <= rem; d += 2) begin
      e = 1;
      while (rem % d == 0) begin
        e++;
        rem = rem / d;
      end
      res.divisor_count = sat_mul(res.divisor_count, e);
    end
    if (rem != 1) res.divisor_count = sat_mul(res.divisor_count, 2);
    return res;
  endfunction

  assign pending = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    count_t want;
    if (rst) begin
      wr_ptr     = '0;
      rd_ptr     = '0;
      wr_cnt     = 0;
      rd_cnt     = 0;
      fail_count = 0;
    end else begin
      // request accepted: store its count
      if (s_axis_tvalid && s_axis_tready) begin
        count_fifo[wr_ptr] = count_divisors(s_axis_tdata);
        wr_ptr = wr_ptr + 1'b1;
        wr_cnt++;
      end
      // result accepted: compare with the oldest count
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_cnt == rd_cnt) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: count %0d zero %0b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = count_fifo[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          rd_cnt++;
          if (want.divisor_count !== m_axis_tdata || want.zero_input !== m_axis_tuser) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected count %0d zero %0b, got count %0d zero %0b",
                       want.divisor_count, want.zero_input, m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_divisor_count_trial_division.sv =====
// ----------------------------------------------------------------------------
// tb_divisor_count_trial_division
// Drives numbers into the divisor counter with random gaps and output stalls;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_divisor_count_trial_division;
  import dcnt_pkg::*;

  localparam longint CycleLimit = 40_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [39:0] number
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] divisor_count
  logic        m_axis_tuser;        // [0] zero_input
  int          fail_count;
  int          pending;
  logic        burst = 1'b0;
  longint      cycles = 0;

  always #5 clk = ~clk;

  divisor_count_trial_division uut (.*);
  divisor_count_checker chk (.*);

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("divisor_count_trial_division verification failed");
      $finish;
    end
  end

  // Result side: random stall before each result, none during bursts
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Send one request; called at a falling edge, returns at a falling edge
  task automatic send_number(logic [39:0] number);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Product of a few small factors: deep factor structure, cheap to run
  function automatic logic [39:0] smooth_number();
    longint unsigned n;
    longint unsigned f;
    int              k;
    n = 1;
    k = $urandom_range(1, 14);
    repeat (k) begin
      f = $urandom_range(2, 97);
      if (n * f < 64'd1 << 40) n = n * f;
    end
    return n[39:0];
  endfunction

  initial begin
    logic [39:0] num;
    int          pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, one, small primes, powers of two, 720720, all ones, a large prime, shifted masks, large semiprime
    send_number(40'd0);
    send_number(40'd1);
    send_number(40'd2);
    send_number(40'd3);
    send_number(40'd4);
    send_number(40'd720720);
    send_number(40'd65536);
    send_number(40'h80_0000_0000);
    send_number(40'hFF_FFFF_FFFF);
    send_number(40'd999983);
    send_number(40'd1023 << 30);
    send_number(40'hFF_0000_0000);
    send_number(40'd999983 * 40'd999979);

    // random part
    for (int i = 0; i < 100; i++) begin
      if (i % 20 == 0) burst = ~burst;
      pick = $urandom_range(0, 9);
      if (pick < 5) num = 40'($urandom_range(1, 65535)) << $urandom_range(0, 24);
      else if (pick < 8) num = smooth_number();
      else num = 40'($urandom_range(0, 1 << 20));
      send_number(num);
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("divisor_count_trial_division verification clean");
    end else begin
      $display("divisor_count_trial_division verification failed");
    end
    $finish;
  end

endmodule

// ===== divisor_count_trial_division.f =====
hw/rtl/dcnt_pkg.sv
hw/rtl/dcnt_ram.sv
hw/rtl/dcnt_div.sv
hw/rtl/divisor_count_trial_division.sv
tb/divisor_count_checker.sv
tb/tb_divisor_count_trial_division.sv
